@@ hdl/rsag_pkg.sv @@
// Shared package for the reverse-sequence address generator.
// Holds sizes, command and register codes, payload structs and field helpers.
// No dependencies.
`timescale 1ns / 1ps

package rsag_pkg;

    localparam int RANK       = 4;
    localparam int DIM_BITS   = 16;
    localparam int MAX_BATCH  = 256;
    localparam int BATCH_BITS = $clog2(MAX_BATCH);
    localparam int IDX_BITS   = 8;
    localparam int LEN_BITS   = 16;
    localparam int OFS_BITS   = 32;
    localparam int CFG_BITS   = 64;
    localparam int SEL_BITS   = 2;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_BITS-1:0] SHAPE_RESET  = 64'h0001_0001_0001_0001;
    localparam logic [CFG_BITS-1:0] STRIDE_RESET = '0;
    localparam logic [SEL_BITS-1:0] BATCH_SEL_RESET = 2'd0;
    localparam logic [SEL_BITS-1:0] TIME_SEL_RESET  = 2'd1;

    typedef enum logic {
        CMD_WRITE_LEN = 1'b0,
        CMD_STEP      = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SHAPE_DIMS  = 3'd0,
        CFG_SRC_STRIDES = 3'd1,
        CFG_DST_STRIDES = 3'd2,
        CFG_BATCH_SEL   = 3'd3,
        CFG_TIME_SEL    = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [IDX_BITS-1:0] batch_index;
        logic [LEN_BITS-1:0] seq_length;
    } in_t;

    typedef struct packed {
        logic [OFS_BITS-1:0] src_offset;
        logic [OFS_BITS-1:0] dst_offset;
        logic                last_element;
    } out_t;

    typedef logic [RANK-1:0][DIM_BITS-1:0] coord_vec_t;
    typedef logic [RANK-1:0][OFS_BITS-1:0] prod_vec_t;

    // Field i of a packed word; dimension 0 sits in the top bits.
    function automatic logic [DIM_BITS-1:0] dim_field(input logic [CFG_BITS-1:0] word,
                                                      input int i);
        return word[DIM_BITS*(RANK-1-i) +: DIM_BITS];
    endfunction

    // A zero dimension size counts as one.
    function automatic logic [DIM_BITS-1:0] dim_size(input logic [CFG_BITS-1:0] word,
                                                     input int i);
        logic [DIM_BITS-1:0] f;
        f = dim_field(word, i);
        return (f == '0) ? DIM_BITS'(1) : f;
    endfunction

endpackage

@@ hdl/rsag_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// The read register loads only when the read enable is high.
`timescale 1ns / 1ps

module rsag_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/reverse_sequence_address_gen_top.sv @@
// Top level of the reverse-sequence address generator.
// Depends on rsag_pkg and instantiates rsag_ram for the sequence length table.
`timescale 1ns / 1ps

// Usage
// The input channel (s_valid, s_ready, s_data) carries two kinds of transaction.
// A write-length transaction stores a sequence length for one batch entry and
// produces no result. A step transaction produces one result on the output
// channel (m_valid, m_ready, m_data): the source and destination element
// offsets of the current walk position, plus a flag on the final element.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// shape, strides and the batch and time selectors; it is always ready, and it
// should only be used while no step transaction is in flight.
// A step's result goes through the s1, s2, s3 and output registers to m_valid.
// Throughput is one transaction per cycle unless stalled: the length table is
// read through the single read port of its RAM, one entry per step, and the walk
// counter advances at acceptance so consecutive steps never wait on each other.
// Reset clears the walk position, loads the default configuration and marks
// every length entry as empty (reads as zero) through per-entry valid bits;
// no clearing pass is needed, so the block is ready right after reset.
// When the receiver stalls, results pile up in the pipeline stages and the
// output register; s_ready drops only once all of them are full.

module reverse_sequence_address_gen_top
    import rsag_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  in_t                     s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output out_t                    m_data,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data
);

    // Configuration registers.
    logic [CFG_BITS-1:0] shape_reg, shape_next;
    logic [CFG_BITS-1:0] src_strides_reg, src_strides_next;
    logic [CFG_BITS-1:0] dst_strides_reg, dst_strides_next;
    logic [SEL_BITS-1:0] batch_sel_reg, batch_sel_next;
    logic [SEL_BITS-1:0] time_sel_reg, time_sel_next;

    // Walk position and length-table valid bits.
    coord_vec_t           coord_reg, coord_next;
    logic [MAX_BATCH-1:0] len_valid_reg, len_valid_next;

    // Pipeline stages.
    logic       s1_valid_reg, s1_hit_reg, s1_last_reg;
    coord_vec_t s1_coord_reg;
    logic       s2_valid_reg, s2_last_reg;
    coord_vec_t s2_src_reg, s2_dst_reg;
    logic       s3_valid_reg, s3_last_reg;
    prod_vec_t  s3_src_p_reg, s3_dst_p_reg;
    logic       out_valid_reg;
    out_t       out_reg, out_next;

    logic s_fire, step_fire, write_fire;
    logic out_load, s3_load, s2_load, s1_load;

    logic                  walk_last;
    logic [DIM_BITS-1:0]   batch_coord;
    logic                  batch_in_table;
    logic [BATCH_BITS-1:0] rd_addr;
    logic [BATCH_BITS-1:0] wr_addr;
    logic                  wr_en;
    logic [LEN_BITS-1:0]   ram_rdata;

    coord_vec_t          src_coord;
    logic [LEN_BITS-1:0] len_raw, len_clamped;
    logic [DIM_BITS-1:0] time_coord, time_dim;

    // Handshakes. Each stage loads when it is empty or when its content moves on.
    assign out_load  = !out_valid_reg || m_ready;
    assign s3_load   = !s3_valid_reg || out_load;
    assign s2_load   = !s2_valid_reg || s3_load;
    assign s1_load   = !s1_valid_reg || s2_load;
    assign s_ready   = s1_load;
    assign s_fire    = s_valid && s_ready;
    assign step_fire = s_fire && (s_data.cmd == CMD_STEP);
    assign write_fire = s_fire && (s_data.cmd == CMD_WRITE_LEN);
    assign cfg_ready = 1'b1;

    // Configuration decode.
    always_comb begin
        shape_next       = shape_reg;
        src_strides_next = src_strides_reg;
        dst_strides_next = dst_strides_reg;
        batch_sel_next   = batch_sel_reg;
        time_sel_next    = time_sel_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SHAPE_DIMS:  shape_next       = cfg_data;
                CFG_SRC_STRIDES: src_strides_next = cfg_data;
                CFG_DST_STRIDES: dst_strides_next = cfg_data;
                CFG_BATCH_SEL:   batch_sel_next   = cfg_data[SEL_BITS-1:0];
                CFG_TIME_SEL:    time_sel_next    = cfg_data[SEL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Row-major walk: the last dimension counts fastest. A coordinate at or past
    // the end of its dimension wraps to zero and carries into the next one out.
    always_comb begin
        logic                carry;
        logic [DIM_BITS-1:0] end_coord;
        coord_next = coord_reg;
        carry      = 1'b1;
        for (int i = RANK - 1; i >= 0; i--) begin
            end_coord = dim_size(shape_reg, i) - DIM_BITS'(1);
            if (carry) begin
                if (coord_reg[i] >= end_coord) begin
                    coord_next[i] = '0;
                end else begin
                    coord_next[i] = coord_reg[i] + DIM_BITS'(1);
                    carry         = 1'b0;
                end
            end
        end
        walk_last = carry;
    end

    // Length table lookup for the current batch coordinate. Entries never
    // written since reset read as zero through their valid bit, and so does a
    // batch coordinate beyond the table.
    assign batch_coord    = coord_reg[batch_sel_reg];
    assign batch_in_table = (batch_coord[DIM_BITS-1:BATCH_BITS] == '0);
    assign rd_addr        = batch_coord[BATCH_BITS-1:0];
    assign wr_addr        = s_data.batch_index[BATCH_BITS-1:0];
    assign wr_en          = write_fire && (int'(s_data.batch_index) < MAX_BATCH);

    always_comb begin
        len_valid_next = len_valid_reg;
        if (wr_en) begin
            len_valid_next[wr_addr] = 1'b1;
        end
    end

    // The read register holds while stage one stalls, so a later write to the
    // same entry cannot change a length that a step has already looked up.
    rsag_ram #(
        .WIDTH (LEN_BITS),
        .DEPTH (MAX_BATCH)
    ) u_len_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (s_data.seq_length),
        .re    (step_fire),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Stage one: clamp the length to the time dimension and mirror the time
    // coordinate when it lies inside the sequence.
    always_comb begin
        len_raw     = s1_hit_reg ? ram_rdata : '0;
        time_dim    = dim_size(shape_reg, int'(time_sel_reg));
        time_coord  = s1_coord_reg[time_sel_reg];
        len_clamped = (len_raw > time_dim) ? time_dim : len_raw;
        src_coord   = s1_coord_reg;
        if (time_coord < len_clamped) begin
            src_coord[time_sel_reg] = len_clamped - DIM_BITS'(1) - time_coord;
        end
    end

    // Output stage: sum the stride products, wrapping modulo 2^32.
    always_comb begin
        logic [OFS_BITS-1:0] src_acc;
        logic [OFS_BITS-1:0] dst_acc;
        src_acc = '0;
        dst_acc = '0;
        for (int i = 0; i < RANK; i++) begin
            src_acc = src_acc + s3_src_p_reg[i];
            dst_acc = dst_acc + s3_dst_p_reg[i];
        end
        out_next.src_offset   = src_acc;
        out_next.dst_offset   = dst_acc;
        out_next.last_element = s3_last_reg;
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_reg       <= SHAPE_RESET;
            src_strides_reg <= STRIDE_RESET;
            dst_strides_reg <= STRIDE_RESET;
            batch_sel_reg   <= BATCH_SEL_RESET;
            time_sel_reg    <= TIME_SEL_RESET;
            coord_reg       <= '0;
            len_valid_reg   <= '0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            shape_reg       <= shape_next;
            src_strides_reg <= src_strides_next;
            dst_strides_reg <= dst_strides_next;
            batch_sel_reg   <= batch_sel_next;
            time_sel_reg    <= time_sel_next;
            len_valid_reg   <= len_valid_next;
            if (step_fire) begin
                coord_reg <= coord_next;
            end
            if (s1_load) begin
                s1_valid_reg <= step_fire;
            end
            if (s2_load) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_load) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_load) begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_coord_reg <= coord_reg;
            s1_hit_reg   <= batch_in_table && len_valid_reg[rd_addr];
            s1_last_reg  <= walk_last;
        end
        if (s2_load) begin
            s2_src_reg  <= src_coord;
            s2_dst_reg  <= s1_coord_reg;
            s2_last_reg <= s1_last_reg;
        end
        if (s3_load) begin
            for (int i = 0; i < RANK; i++) begin
                s3_src_p_reg[i] <= OFS_BITS'(s2_src_reg[i])
                                 * OFS_BITS'(dim_field(src_strides_reg, i));
                s3_dst_p_reg[i] <= OFS_BITS'(s2_dst_reg[i])
                                 * OFS_BITS'(dim_field(dst_strides_reg, i));
            end
            s3_last_reg <= s2_last_reg;
        end
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

@@ hdl/rsag_checker.sv @@
// Port-level checker for the reverse-sequence address generator, with its bind.
// Depends on rsag_pkg and on the ports of reverse_sequence_address_gen_top.
`timescale 1ns / 1ps

module rsag_checker
    import rsag_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data,
    input logic cfg_valid,
    input logic cfg_ready
);

    // A stalled result stays and holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed or vanished while stalled");

    // The input side only backs up when the output side is stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input not ready although the output is free");

    // Reset empties the output register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result shown right after reset");

    // Configuration writes are never back-pressured.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind reverse_sequence_address_gen_top rsag_checker u_rsag_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

@@ tb/tb_reverse_sequence_address_gen_top.sv @@
// Self-checking testbench for reverse_sequence_address_gen_top.
// Depends on rsag_pkg and the block's RTL. It holds an offset-pair scoreboard
// class with its own model of the walk and length table.
`timescale 1ns / 1ps

module tb_reverse_sequence_address_gen_top;
    import rsag_pkg::*;

    // A generous bound on the whole run, even with the heaviest idling.
    localparam int LIMIT_CYCLES = 400000;
    // Cycles to let pass once the last result is in, so that trailing
    // write-length transactions (which make no result) are through the pipe.
    localparam int DRAIN_CYCLES = 12;
    // Length of the long receiver hold-off that fills the block up.
    localparam int HOLD_CYCLES  = 300;
    // An index past the end of the register list; writes to it are dropped.
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_UNUSED = 3'd7;

    typedef enum int {
        PH_SMALL,       // small random shape, random strides and selectors
        PH_UNIT,        // every dimension zero, so every step ends the walk
        PH_HUGE,        // largest shape and source strides, longest lengths
        PH_WIDE_BATCH   // batch dimension wider than the length table
    } phase_kind_t;

    // Keeps a private copy of the configuration, walk position and length
    // table, predicts the offset pair of every accepted step and checks
    // the results against it in order.
    class offset_pair_scoreboard;
        logic [DIM_BITS-1:0] dim_len    [RANK];
        logic [DIM_BITS-1:0] src_stride [RANK];
        logic [DIM_BITS-1:0] dst_stride [RANK];
        logic [SEL_BITS-1:0] batch_sel;
        logic [SEL_BITS-1:0] time_sel;
        logic [DIM_BITS-1:0] walk_pos   [RANK];
        logic [LEN_BITS-1:0] seq_len_table [MAX_BATCH];
        out_t                expected_pairs [$];
        int                  errors;

        function new();
            for (int i = 0; i < RANK; i++) begin
                dim_len[i]    = 16'd1;
                src_stride[i] = '0;
                dst_stride[i] = '0;
                walk_pos[i]   = '0;
            end
            for (int b = 0; b < MAX_BATCH; b++) begin
                seq_len_table[b] = '0;
            end
            batch_sel = 2'd0;
            time_sel  = 2'd1;
            errors    = 0;
        endfunction

        // Appends one predicted pair at the tail of the queue.
        function void enqueue_pair(out_t pair);
            expected_pairs = {expected_pairs, pair};
        endfunction

        function void load_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
            // Dimension 0 sits in the top 16 bits of each packed word.
            for (int i = 0; i < RANK; i++) begin
                case (idx)
                    CFG_SHAPE_DIMS: begin
                        dim_len[i] = data[CFG_BITS-1-DIM_BITS*i -: DIM_BITS];
                        if (dim_len[i] == '0) dim_len[i] = 16'd1;
                    end
                    CFG_SRC_STRIDES: src_stride[i] = data[CFG_BITS-1-DIM_BITS*i -: DIM_BITS];
                    CFG_DST_STRIDES: dst_stride[i] = data[CFG_BITS-1-DIM_BITS*i -: DIM_BITS];
                    default: ;
                endcase
            end
            if (idx == CFG_BATCH_SEL) batch_sel = data[SEL_BITS-1:0];
            if (idx == CFG_TIME_SEL)  time_sel  = data[SEL_BITS-1:0];
        endfunction

        function void accept_item(in_t item);
            logic [DIM_BITS-1:0] read_pos [RANK];
            logic [DIM_BITS-1:0] batch, seq_len, t;
            logic [OFS_BITS-1:0] src_acc, dst_acc;
            out_t                pair;
            bit                  carry;
            if (item.cmd == CMD_WRITE_LEN) begin
                seq_len_table[item.batch_index] = item.seq_length;
                return;
            end
            for (int i = 0; i < RANK; i++) read_pos[i] = walk_pos[i];
            // A batch coordinate past the table reads as length zero.
            batch   = walk_pos[batch_sel];
            seq_len = (batch < MAX_BATCH) ? seq_len_table[batch[BATCH_BITS-1:0]] : '0;
            if (seq_len > dim_len[time_sel]) seq_len = dim_len[time_sel];
            t = walk_pos[time_sel];
            if (t < seq_len) read_pos[time_sel] = seq_len - 16'd1 - t;
            src_acc = '0;
            dst_acc = '0;
            for (int i = 0; i < RANK; i++) begin
                src_acc += 32'(read_pos[i]) * 32'(src_stride[i]);
                dst_acc += 32'(walk_pos[i]) * 32'(dst_stride[i]);
            end
            // Row-major increment; a coordinate at or past its end wraps and carries.
            carry = 1'b1;
            for (int i = RANK - 1; i >= 0; i--) begin
                if (carry) begin
                    if (walk_pos[i] >= dim_len[i] - 16'd1) begin
                        walk_pos[i] = '0;
                    end else begin
                        walk_pos[i] = walk_pos[i] + 16'd1;
                        carry = 1'b0;
                    end
                end
            end
            pair.src_offset   = src_acc;
            pair.dst_offset   = dst_acc;
            pair.last_element = carry;
            enqueue_pair(pair);
        endfunction

        function void compare_pair(out_t got);
            out_t want;
            if (expected_pairs.size() == 0) begin
                $error("unexpected result: src_offset %0h dst_offset %0h last_element %0b",
                       got.src_offset, got.dst_offset, got.last_element);
                errors++;
                return;
            end
            want = expected_pairs.pop_front();
            if (got.src_offset !== want.src_offset) begin
                $error("src_offset: expected %0h, actual %0h", want.src_offset, got.src_offset);
                errors++;
            end
            if (got.dst_offset !== want.dst_offset) begin
                $error("dst_offset: expected %0h, actual %0h", want.dst_offset, got.dst_offset);
                errors++;
            end
            if (got.last_element !== want.last_element) begin
                $error("last_element: expected %0b, actual %0b",
                       want.last_element, got.last_element);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_pairs.size();
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_valid   = 1'b0;
    logic                    s_ready;
    in_t                     s_data    = '0;
    logic                    m_valid;
    logic                    m_ready   = 1'b0;
    out_t                    m_data;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]     cfg_data  = '0;

    offset_pair_scoreboard sb;

    // Idle rates in percent, changed between modes by the stimulus process.
    int send_idle_pct = 12;
    int recv_idle_pct = 85;
    // The stimulus process bumps hold_req; the receiver process notices the
    // change and counts out the hold-off on its own.
    int hold_req  = 0;
    int hold_ack  = 0;
    int hold_left = 0;
    int cycle_count = 0;
    // Batch and time dimension sizes of the current random phase.
    int cur_bdim = 1;
    int cur_tdim = 1;

    reverse_sequence_address_gen_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: random back-pressure, or a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES - 1;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: all handshakes are sampled at the rising edge, before any of
    // this edge's nonblocking updates land. A configuration write and an
    // input transaction are folded into the model before results are checked.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.load_register(cfg_index, cfg_data);
            if (s_valid && s_ready)     sb.accept_item(s_data);
            if (m_valid && m_ready)     sb.compare_pair(m_data);
        end
    end

    // Offers one input transaction, after a random number of idle cycles,
    // and returns at the edge where it is accepted. Valid stays high from
    // here to the next call if that call does not idle.
    task automatic send_item(input in_t item);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Writes one register and returns at the accepting edge with valid still high.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Waits until every predicted result has come back, then lets the pipe empty.
    task automatic wait_drain();
        do @(posedge aclk); while (sb.outstanding() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic in_t step_item();
        in_t it;
        it.cmd         = CMD_STEP;
        it.batch_index = 8'($urandom_range(0, 255));
        it.seq_length  = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    function automatic logic [DIM_BITS-1:0] pick_stride();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    // Random transaction: mostly steps, with length writes aimed mostly at
    // the batch entries and lengths that the current shape can reach.
    function automatic in_t make_item(input int write_pct);
        in_t it;
        int  hi;
        it = step_item();
        if ($urandom_range(0, 99) < write_pct) begin
            it.cmd = CMD_WRITE_LEN;
            hi = (cur_bdim > MAX_BATCH) ? MAX_BATCH - 1 : cur_bdim - 1;
            if ($urandom_range(0, 99) < 80) it.batch_index = 8'($urandom_range(0, hi));
            if ($urandom_range(0, 99) < 70) it.seq_length = 16'($urandom_range(0, cur_tdim + 1));
        end
        return it;
    endfunction

    // Picks and writes a whole configuration for the next phase.
    task automatic random_config(input phase_kind_t kind);
        logic [DIM_BITS-1:0] d  [RANK];
        logic [DIM_BITS-1:0] ss [RANK];
        logic [DIM_BITS-1:0] ds [RANK];
        logic [CFG_BITS-1:0] sel_word;
        int bsel, tsel;
        bsel = $urandom_range(0, 3);
        tsel = $urandom_range(0, 3);
        for (int i = 0; i < RANK; i++) begin
            d[i]  = 16'($urandom_range(0, 3));
            ss[i] = pick_stride();
            ds[i] = pick_stride();
        end
        case (kind)
            PH_SMALL: d[tsel] = 16'($urandom_range(0, 6));
            PH_UNIT: begin
                for (int i = 0; i < RANK; i++) begin
                    d[i]  = 16'h0000;
                    ss[i] = 16'hFFFF;
                    ds[i] = 16'hFFFF;
                end
            end
            PH_HUGE: begin
                for (int i = 0; i < RANK; i++) begin
                    d[i]  = 16'hFFFF;
                    ss[i] = 16'hFFFF;
                end
                bsel = 0;
                tsel = 3;
            end
            default: begin
                // 300 batch entries on the innermost dimension, time outermost.
                d[0] = 16'd2;
                d[1] = 16'd1;
                d[2] = 16'd1;
                d[3] = 16'd300;
                bsel = 3;
                tsel = 0;
            end
        endcase
        cur_bdim = (d[bsel] == '0) ? 1 : int'(d[bsel]);
        cur_tdim = (d[tsel] == '0) ? 1 : int'(d[tsel]);
        write_reg(CFG_SHAPE_DIMS,  {d[0], d[1], d[2], d[3]});
        write_reg(CFG_SRC_STRIDES, {ss[0], ss[1], ss[2], ss[3]});
        write_reg(CFG_DST_STRIDES, {ds[0], ds[1], ds[2], ds[3]});
        // Only the low selector bits count; the rest carry noise.
        sel_word = {$urandom(), $urandom()};
        sel_word[SEL_BITS-1:0] = SEL_BITS'(bsel);
        write_reg(CFG_BATCH_SEL, sel_word);
        sel_word = {$urandom(), $urandom()};
        sel_word[SEL_BITS-1:0] = SEL_BITS'(tsel);
        write_reg(CFG_TIME_SEL, sel_word);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_items(input int count, input int write_pct);
        for (int i = 0; i < count; i++) send_item(make_item(write_pct));
        s_valid <= 1'b0;
    endtask

    initial begin
        phase_kind_t kind;
        int          n_items;
        int          write_pct;
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. Shape 2 x 3 x 0 x 2: batch on dimension 0, time on
        // dimension 1, and dimension 2 at zero so it counts as one.
        write_reg(CFG_SHAPE_DIMS,  64'h0002_0003_0000_0002);
        write_reg(CFG_SRC_STRIDES, 64'hFFFF_1000_0007_0001);
        write_reg(CFG_DST_STRIDES, 64'h0100_0010_0003_0001);
        write_reg(CFG_BATCH_SEL,   64'd0);
        write_reg(CFG_TIME_SEL,    64'd1);
        cfg_valid <= 1'b0;
        // Batch 0 gets a length past the time dimension, which clamps to 3.
        // Batch 1 gets zero and is not reversed. The last entry takes the
        // largest length.
        send_item('{CMD_WRITE_LEN, 8'd0,   16'd5});
        send_item('{CMD_WRITE_LEN, 8'd1,   16'd0});
        send_item('{CMD_WRITE_LEN, 8'd255, 16'hFFFF});
        // The full 12-element walk ends with the last-element flag, then
        // one step more starts the next walk.
        repeat (13) send_item(step_item());
        s_valid <= 1'b0;
        wait_drain();
        // Shrinking the shape mid-walk leaves the innermost coordinate past
        // its dimension; it is emitted as is and then wraps with a carry.
        write_reg(CFG_SHAPE_DIMS, 64'h0001_0001_0001_0001);
        write_reg(CFG_IDX_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_valid <= 1'b0;
        repeat (2) send_item(step_item());
        s_valid <= 1'b0;
        wait_drain();
        // The same dimension selects the length and is reversed.
        write_reg(CFG_SHAPE_DIMS, 64'h0000_0000_0004_0000);
        write_reg(CFG_BATCH_SEL,  64'd2);
        write_reg(CFG_TIME_SEL,   64'd2);
        cfg_valid <= 1'b0;
        send_item('{CMD_WRITE_LEN, 8'd2, 16'd4});
        repeat (4) send_item(step_item());
        s_valid <= 1'b0;

        // Random part in three idling modes. The last mode has no idling,
        // opens with a long receiver hold-off and walks a batch dimension
        // wider than the length table.
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle_pct = 12;
                    recv_idle_pct = 85;
                end
                1: begin
                    send_idle_pct = 85;
                    recv_idle_pct = 12;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int ph = 0; ph < 4; ph++) begin
                kind      = PH_SMALL;
                n_items   = 60;
                write_pct = 20;
                if (mode < 2) begin
                    if (ph == 1) kind = (mode == 0) ? PH_UNIT : PH_HUGE;
                end else begin
                    case (ph)
                        0: n_items = 80;
                        1: begin
                            kind    = PH_UNIT;
                            n_items = 20;
                        end
                        2: begin
                            kind      = PH_WIDE_BATCH;
                            n_items   = 300;
                            write_pct = 10;
                        end
                        default: n_items = 100;
                    endcase
                end
                // The sender holds back here until every result is in.
                wait_drain();
                random_config(kind);
                if (mode == 2 && ph == 0) hold_req <= hold_req + 1;
                run_items(n_items, write_pct);
            end
        end

        wait_drain();
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
